// ----- rtl/bfd_pkg.sv -----
// Shared types and constants for the byte-stuffed frame decoder.
package bfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 13;
  localparam int unsigned IdxW  = 3;

  // Hard ceiling on the frame length limit, whatever max_length says.
  localparam logic [LenW-1:0] LengthLimit = 13'd4096;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DROP_NONE   = 2'd0,
    DROP_ESCAPE = 2'd1,
    DROP_LONG   = 2'd2
  } drop_e;

  typedef enum logic [IdxW-1:0] {
    CFG_FLAG_CHAR   = 3'd0,
    CFG_ESCAPE_CHAR = 3'd1,
    CFG_FLAG_CODE   = 3'd2,
    CFG_ESCAPE_CODE = 3'd3,
    CFG_MAX_LENGTH  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] flag_char;
    logic [ByteW-1:0] escape_char;
    logic [ByteW-1:0] flag_escape_code;
    logic [ByteW-1:0] escape_escape_code;
    logic [LenW-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  frame_length;
    drop_e            drop_reason;
  } result_t;

endpackage

// ----- rtl/bfd_cfg_regs.sv -----
// Configuration register file of the frame decoder.
module bfd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfd_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [bfd_pkg::LenW-1:0]  cfg_data_i,
  output bfd_pkg::cfg_t             cfg_o
);

  bfd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_char          <= 8'd126;
      cfg_q.escape_char        <= 8'd125;
      cfg_q.flag_escape_code   <= 8'd2;
      cfg_q.escape_escape_code <= 8'd1;
      cfg_q.max_length         <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfd_pkg::CFG_FLAG_CHAR:   cfg_q.flag_char <= cfg_data_i[bfd_pkg::ByteW-1:0];
        bfd_pkg::CFG_ESCAPE_CHAR: cfg_q.escape_char <= cfg_data_i[bfd_pkg::ByteW-1:0];
        bfd_pkg::CFG_FLAG_CODE:   cfg_q.flag_escape_code <= cfg_data_i[bfd_pkg::ByteW-1:0];
        bfd_pkg::CFG_ESCAPE_CODE: cfg_q.escape_escape_code <= cfg_data_i[bfd_pkg::ByteW-1:0];
        bfd_pkg::CFG_MAX_LENGTH:  cfg_q.max_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bfd_core.sv -----
// Input register, frame state and per-byte decode logic.
module bfd_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bfd_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                      res_valid_o,
  output bfd_pkg::result_t          res_o,
  input  logic                      res_ready_i
);

  logic                      s1_valid_q, s1_valid_d;
  logic [bfd_pkg::ByteW-1:0] s1_byte_q;
  logic                      hunt_q, hunt_d;
  logic [bfd_pkg::LenW-1:0]  cnt_q, cnt_d;
  logic [bfd_pkg::ByteW-1:0] prev_q, prev_d;
  logic                      has_res;
  logic                      fire;
  logic                      in_fire;
  logic [bfd_pkg::LenW-1:0]  limit;

  assign limit = (cfg_i.max_length > bfd_pkg::LengthLimit) ? bfd_pkg::LengthLimit
                                                           : cfg_i.max_length;

  always_comb begin
    logic [bfd_pkg::ByteW-1:0] cur;
    logic [bfd_pkg::ByteW-1:0] dec;
    logic [bfd_pkg::LenW-1:0]  cnt_n;
    logic                      have;
    logic                      bad;
    cur     = s1_byte_q;
    dec     = '0;
    cnt_n   = cnt_q;
    have    = 1'b0;
    bad     = 1'b0;
    hunt_d  = hunt_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    has_res = 1'b0;
    res_o   = '{kind: bfd_pkg::KIND_DATA, data_byte: '0, frame_length: '0,
                drop_reason: bfd_pkg::DROP_NONE};
    if (hunt_q) begin
      if (cur == cfg_i.flag_char) begin
        hunt_d = 1'b0;
        cnt_d  = '0;
        prev_d = '0;
      end
    end else if (cur == cfg_i.flag_char) begin
      // repeated flags before the body are skipped
      if (cnt_q != '0) begin
        hunt_d             = 1'b1;
        has_res            = 1'b1;
        res_o.kind         = bfd_pkg::KIND_DONE;
        res_o.frame_length = cnt_q;
      end
    end else begin
      if (prev_q == cfg_i.escape_char) begin
        if (cur == cfg_i.flag_escape_code) begin
          dec  = cfg_i.flag_char;
          have = 1'b1;
        end else if (cur == cfg_i.escape_escape_code) begin
          dec  = cfg_i.escape_char;
          have = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end else begin
        if (cur != cfg_i.escape_char) begin
          dec  = cur;
          have = 1'b1;
        end
        cnt_n = cnt_q + 1'b1;
      end
      if (bad) begin
        hunt_d            = 1'b1;
        has_res           = 1'b1;
        res_o.kind        = bfd_pkg::KIND_DROP;
        res_o.drop_reason = bfd_pkg::DROP_ESCAPE;
      end else begin
        prev_d = cur;
        cnt_d  = cnt_n;
        if (cnt_n >= limit) begin
          hunt_d            = 1'b1;
          has_res           = 1'b1;
          res_o.kind        = bfd_pkg::KIND_DROP;
          res_o.drop_reason = bfd_pkg::DROP_LONG;
        end else if (have) begin
          has_res         = 1'b1;
          res_o.data_byte = dec;
        end
      end
    end
  end

  // an item with no result leaves even while the output is stalled
  assign fire        = s1_valid_q && (!has_res || res_ready_i);
  assign res_valid_o = s1_valid_q && has_res;
  assign in_stall_o  = s1_valid_q && !fire;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hunt_q     <= 1'b1;
      cnt_q      <= '0;
      prev_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (fire) begin
        hunt_q <= hunt_d;
        cnt_q  <= cnt_d;
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
    end
  end

endmodule

// ----- rtl/bfd_out_reg.sv -----
// Result register that drives the output channel.
module bfd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  bfd_pkg::result_t res_i,
  output logic             res_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bfd_pkg::result_t out_o
);

  logic             valid_q, valid_d;
  bfd_pkg::result_t res_q;

  assign res_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ----- rtl/byte_stuffed_frame_decoder.sv -----
// Byte-stuffed frame decoder: one raw link byte in per item, at most one result out per item;
// a new byte is taken every cycle unless the input stalls, a result reaches the output
// via the input register, then the result register, and bytes that give no result (hunting,
// repeated flags, escape bytes) pass the input register even while the output side is
// stalled, so input stalls only when a waiting result blocks the next one. Configuration
// writes take effect on the next byte and should be made only while the block is idle.
module byte_stuffed_frame_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfd_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [bfd_pkg::LenW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [bfd_pkg::ByteW-1:0] data_byte_o,
  output logic [bfd_pkg::LenW-1:0]  frame_length_o,
  output logic [1:0]                drop_reason_o
);

  bfd_pkg::cfg_t    cfg;
  bfd_pkg::result_t res;
  bfd_pkg::result_t out;
  logic             res_valid;
  logic             res_ready;

  bfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  bfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign kind_o         = out.kind;
  assign data_byte_o    = out.data_byte;
  assign frame_length_o = out.frame_length;
  assign drop_reason_o  = out.drop_reason;

endmodule

// ----- rtl/bfd_checker.sv -----
// Port-level checks for the frame decoder, bound to the top level.
module bfd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                kind_o,
  input logic [bfd_pkg::ByteW-1:0] data_byte_o,
  input logic [bfd_pkg::LenW-1:0]  frame_length_o,
  input logic [1:0]                drop_reason_o
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o)
      && $stable(frame_length_o) && $stable(drop_reason_o))
    else $error("stalled output item changed");

  // input backs up only behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == bfd_pkg::KIND_DONE |->
      frame_length_o != '0 && data_byte_o == '0 && drop_reason_o == bfd_pkg::DROP_NONE)
    else $error("bad frame-complete item");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == bfd_pkg::KIND_DROP |->
      (drop_reason_o == bfd_pkg::DROP_ESCAPE || drop_reason_o == bfd_pkg::DROP_LONG)
      && frame_length_o == '0 && data_byte_o == '0)
    else $error("bad frame-drop item");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == bfd_pkg::KIND_DATA |->
      frame_length_o == '0 && drop_reason_o == bfd_pkg::DROP_NONE)
    else $error("bad data item");

endmodule

bind byte_stuffed_frame_decoder bfd_checker u_bfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .data_byte_o    (data_byte_o),
  .frame_length_o (frame_length_o),
  .drop_reason_o  (drop_reason_o)
);
